// File: hdl/lp2c_pkg.sv
// Package for the laser polar-to-Cartesian converter.
// Holds the sequencer state type, register indexes, fixed-point constants and the arctangent table.
// No dependencies.
package lp2c_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KMUL,
		ST_ROT,
		ST_DONE
	} state_t;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_START  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_STEP   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DIST_LO      = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_DIST_HI      = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SCALE_TO_MAP = 3'd4;

	localparam logic [31:0] ANGLE_START_RST  = 32'd0;
	localparam logic [31:0] ANGLE_STEP_RST   = 32'd0;
	localparam logic [15:0] DIST_LO_RST      = 16'd0;
	localparam logic [15:0] DIST_HI_RST      = 16'd65535;
	localparam logic [15:0] SCALE_TO_MAP_RST = 16'd10240;

	// 0.1 m in 1/1024 m
	localparam logic [16:0] RANGE_MARGIN = 17'd102;
	// 1/K of the CORDIC, Q30
	localparam logic [29:0] KINV_Q30 = 30'd652032874;

	localparam int unsigned TABLE_LEN = 24;
	localparam int unsigned OUT_W     = 23;

	// arctan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_turns(input logic [4:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hdl/laser_polar_to_cartesian.sv
// Laser polar-to-Cartesian converter: beam angle tracking, range gate, scaling and CORDIC rotation.
// Depends on lp2c_pkg.
//
// One range sample per input transaction; s_tuser high marks the first beam of a scan and
// reloads the beam angle from angle_start, otherwise angle_step is added. A sample strictly
// inside (minimum range, maximum range - 0.1 m) produces one output transaction with
// x = cos * d and y = sin * d in 1/256 map cell, saturated to 23 bits; any other sample updates
// the angle only and produces nothing. A gated-in sample occupies the core while the 1/K
// scaling multiplies one byte of range*scale per cycle over its four bytes, then the shared
// CORDIC stage runs one iteration per cycle, then the result is rounded into the output
// register. A rejected sample does not occupy the core. The output register lets the next
// sample start while a result waits for m_tready.
module laser_polar_to_cartesian #(
	parameter int unsigned ANGLE_BITS    = 32,
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave: range [15:0]
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,
	// slave tuser: scan_start [0]
	input  logic                                s_tuser,
	// master: x [22:0], y [45:23], zero [47:46]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [47:0]                         m_tdata,
	input  logic                                cfg_we,
	input  logic [lp2c_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lp2c_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int unsigned NSTG  = (CORDIC_STAGES < lp2c_pkg::TABLE_LEN) ?
		CORDIC_STAGES : lp2c_pkg::TABLE_LEN;
	localparam int unsigned CNT_W = $clog2(NSTG);
	localparam logic [CNT_W-1:0] LAST_STG = CNT_W'(NSTG - 1);
	localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam int unsigned OUT_W = lp2c_pkg::OUT_W;

	lp2c_pkg::state_t state_q, state_d;

	logic [31:0] angle_start_q, angle_step_q, beam_angle_q;
	logic [15:0] dist_lo_q, dist_hi_q, scale_q;

	logic [31:0]        prod_q;
	logic [29:0]        acc_q;
	logic [1:0]         dig_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic signed [30:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic               m_valid_q;
	logic [47:0]        m_data_q;

	logic        accept, in_ok, load_out, out_free;
	logic [31:0] next_angle, ang_m, ang_f;
	logic        fold;
	logic [37:0] kmul_sum;
	logic signed [30:0] xs, ys, x_next, y_next;
	logic signed [33:0] z_next, atan_v;

	function automatic logic [OUT_W-1:0] round_sat(input logic signed [30:0] v);
		logic signed [31:0] t;
		logic signed [31:0] r;
		logic [OUT_W-1:0]   res;
		t = 32'(v) + 32'sd32;
		r = t >>> 6;
		if (r > 32'sd4194303) begin
			res = 23'h3FFFFF;
		end else if (r < -32'sd4194304) begin
			res = 23'h400000;
		end else begin
			res = r[OUT_W-1:0];
		end
		return res;
	endfunction

	// handshake and gate
	always_comb begin
		s_tready = (state_q == lp2c_pkg::ST_IDLE);
		accept   = s_tvalid && s_tready;
		in_ok    = (s_tdata > dist_lo_q) &&
			(({1'b0, s_tdata} + lp2c_pkg::RANGE_MARGIN) < {1'b0, dist_hi_q});
		out_free = !m_valid_q || m_tready;
		load_out = (state_q == lp2c_pkg::ST_DONE) && out_free;
		m_tvalid = m_valid_q;
		m_tdata  = m_data_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lp2c_pkg::ST_IDLE: begin
				if (accept && in_ok) state_d = lp2c_pkg::ST_KMUL;
			end
			lp2c_pkg::ST_KMUL: begin
				if (dig_q == 2'd3) state_d = lp2c_pkg::ST_ROT;
			end
			lp2c_pkg::ST_ROT: begin
				if (cnt_q == LAST_STG) state_d = lp2c_pkg::ST_DONE;
			end
			lp2c_pkg::ST_DONE: begin
				if (out_free) state_d = lp2c_pkg::ST_IDLE;
			end
			default: state_d = lp2c_pkg::ST_IDLE;
		endcase
	end

	// datapath
	always_comb begin
		next_angle = s_tuser ? angle_start_q : (beam_angle_q + angle_step_q);
		ang_m      = next_angle & ANGLE_MASK;
		fold       = (ang_m[31:30] == 2'b01) || (ang_m[31:30] == 2'b10);
		ang_f      = fold ? (ang_m ^ 32'h8000_0000) : ang_m;

		// serial 1/K multiply, low byte first; dropped bits are final
		kmul_sum = {8'd0, acc_q} + (38'(prod_q[7:0]) * 38'(lp2c_pkg::KINV_Q30));

		xs     = x_q >>> cnt_q;
		ys     = y_q >>> cnt_q;
		atan_v = 34'(lp2c_pkg::atan_turns(5'(cnt_q)));
		if (!z_q[33]) begin
			x_next = x_q - ys;
			y_next = y_q + xs;
			z_next = z_q - atan_v;
		end else begin
			x_next = x_q + ys;
			y_next = y_q - xs;
			z_next = z_q + atan_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= lp2c_pkg::ANGLE_START_RST;
			angle_step_q  <= lp2c_pkg::ANGLE_STEP_RST;
			dist_lo_q     <= lp2c_pkg::DIST_LO_RST;
			dist_hi_q     <= lp2c_pkg::DIST_HI_RST;
			scale_q       <= lp2c_pkg::SCALE_TO_MAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lp2c_pkg::CFG_ANGLE_START:  angle_start_q <= cfg_wdata;
				lp2c_pkg::CFG_ANGLE_STEP:   angle_step_q  <= cfg_wdata;
				lp2c_pkg::CFG_DIST_LO:      dist_lo_q     <= cfg_wdata[15:0];
				lp2c_pkg::CFG_DIST_HI:      dist_hi_q     <= cfg_wdata[15:0];
				lp2c_pkg::CFG_SCALE_TO_MAP: scale_q       <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lp2c_pkg::ST_IDLE;
			beam_angle_q <= '0;
			m_valid_q    <= 1'b0;
			dig_q        <= '0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			if (accept) beam_angle_q <= next_angle;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				lp2c_pkg::ST_IDLE: begin
					dig_q <= '0;
					cnt_q <= '0;
				end
				lp2c_pkg::ST_KMUL: dig_q <= dig_q + 2'd1;
				lp2c_pkg::ST_ROT:  cnt_q <= cnt_q + CNT_W'(1);
				lp2c_pkg::ST_DONE: cnt_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lp2c_pkg::ST_IDLE: begin
				prod_q <= 32'(s_tdata) * 32'(scale_q);
				acc_q  <= '0;
				neg_q  <= fold;
				z_q    <= 34'(signed'(ang_f));
			end
			lp2c_pkg::ST_KMUL: begin
				acc_q  <= kmul_sum[37:8];
				prod_q <= prod_q >> 8;
				if (dig_q == 2'd3) begin
					x_q <= neg_q ? -signed'(31'(kmul_sum[37:10])) : signed'(31'(kmul_sum[37:10]));
					y_q <= '0;
				end
			end
			lp2c_pkg::ST_ROT: begin
				x_q <= x_next;
				y_q <= y_next;
				z_q <= z_next;
			end
			lp2c_pkg::ST_DONE: begin
				if (load_out) m_data_q <= {2'b00, round_sat(y_q), round_sat(x_q)};
			end
			default: ;
		endcase
	end

endmodule

// File: tb/lp2c_checker.sv
// Scoreboard for laser_polar_to_cartesian: tracks the registers and beam angle from the ports,
// predicts x/y for every gated-in sample and checks output transactions in order.
// Depends on lp2c_pkg for the register indexes.
module lp2c_checker #(
	parameter int unsigned ANGLE_BITS    = 32,
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [15:0]                         s_tdata,
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [47:0]                         m_tdata,
	input  logic                                cfg_we,
	input  logic [lp2c_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lp2c_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output int                                  fail_count,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [22:0] x;
		logic [22:0] y;
	} point_t;

	localparam int          GATE_MARGIN = 102;
	localparam logic [63:0] INV_GAIN    = 64'd652032874;
	localparam longint      SAT_HI      = 4194303;
	localparam longint      SAT_LO      = -4194304;
	localparam logic [31:0] ANGLE_MASK  = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

	// arctan(2^-i), binary angle, entry 0 in the low word
	localparam logic [23:0][31:0] ATAN_TAB = {
		32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608,
		32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886,
		32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838,
		32'd21354465, 32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
	};

	logic [31:0] cfg_start;
	logic [31:0] cfg_step;
	logic [15:0] cfg_rmin;
	logic [15:0] cfg_rmax;
	logic [15:0] cfg_scale;
	logic [31:0] beam_ang;
	point_t      pending_points[$];
	int          errors;

	assign fail_count = errors;

	function automatic logic [22:0] round_sat(input longint v);
		longint r;
		r = (v + 64'sd32) >>> 6;
		if (r > SAT_HI)
			r = SAT_HI;
		else if (r < SAT_LO)
			r = SAT_LO;
		return r[22:0];
	endfunction

	function automatic point_t rotate_beam(input logic [15:0] rng, input logic [15:0] scl,
			input logic [31:0] ang);
		point_t      p;
		logic [63:0] prod;
		logic [31:0] a;
		longint      cx, cy, cz, sx, sy;
		int          i;
		prod = 64'(rng) * 64'(scl) * INV_GAIN;
		cx = longint'(prod >> 34);
		cy = 0;
		a = ang & ANGLE_MASK;
		// second and third quadrant: turn by half a turn, negate start vector
		if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
			a = a - 32'h8000_0000;
			cx = -cx;
		end
		cz = longint'(signed'(a));
		for (i = 0; i < int'(CORDIC_STAGES) && i < 24; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (cz >= 0) begin
				cx = cx - sy;
				cy = cy + sx;
				cz = cz - longint'(ATAN_TAB[i]);
			end else begin
				cx = cx + sy;
				cy = cy - sx;
				cz = cz + longint'(ATAN_TAB[i]);
			end
		end
		p.x = round_sat(cx);
		p.y = round_sat(cy);
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [22:0] got,
			input logic [22:0] want);
		$display("mismatch %s: got %0d expected %0d", what, signed'(got), signed'(want));
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		point_t      want;
		logic [31:0] ang;
		if (!arst_n) begin
			cfg_start = 32'd0;
			cfg_step  = 32'd0;
			cfg_rmin  = 16'd0;
			cfg_rmax  = 16'd65535;
			cfg_scale = 16'd10240;
			beam_ang  = 32'd0;
			errors    = 0;
			pending_points.delete();
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				ang = s_tuser ? cfg_start : beam_ang + cfg_step;
				beam_ang = ang;
				if (s_tdata > cfg_rmin && 32'(s_tdata) + GATE_MARGIN < 32'(cfg_rmax))
					pending_points.insert(pending_points.size(),
						rotate_beam(s_tdata, cfg_scale, ang));
			end
			if (m_tvalid && m_tready) begin
				if (pending_points.size() == 0) begin
					report_mismatch("output transaction with nothing pending, x", m_tdata[22:0],
						23'd0);
				end else begin
					want = pending_points.pop_front();
					if (m_tdata[22:0] !== want.x)
						report_mismatch("x", m_tdata[22:0], want.x);
					if (m_tdata[45:23] !== want.y)
						report_mismatch("y", m_tdata[45:23], want.y);
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					lp2c_pkg::CFG_ANGLE_START:  cfg_start = cfg_wdata;
					lp2c_pkg::CFG_ANGLE_STEP:   cfg_step  = cfg_wdata;
					lp2c_pkg::CFG_DIST_LO:      cfg_rmin  = cfg_wdata[15:0];
					lp2c_pkg::CFG_DIST_HI:      cfg_rmax  = cfg_wdata[15:0];
					lp2c_pkg::CFG_SCALE_TO_MAP: cfg_scale = cfg_wdata[15:0];
					default: ;
				endcase
			end
			pending <= pending_points.size();
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top for laser_polar_to_cartesian: clock, reset, register phases and stream stimulus
// with random stalls; lp2c_checker does the prediction and comparison.
// Depends on lp2c_pkg, laser_polar_to_cartesian and lp2c_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ANGLE_BITS    = 32;
	localparam int unsigned CORDIC_STAGES = 16;
	localparam int          DRAIN_CYCLES  = 40;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          RAND_PHASES   = 8;
	localparam int          PHASE_ITEMS   = 236;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [15:0]                     s_tdata;
	logic                            s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [47:0]                     m_tdata;
	logic                            cfg_we;
	logic [lp2c_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [lp2c_pkg::CFG_DATA_W-1:0] cfg_wdata;
	int                              fail_count;
	int                              pending;
	bit                              src_idle;
	bit                              sink_idle;
	bit                              hold_req;

	laser_polar_to_cartesian #(
		.ANGLE_BITS    (ANGLE_BITS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	lp2c_checker #(
		.ANGLE_BITS    (ANGLE_BITS),
		.CORDIC_STAGES (CORDIC_STAGES)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : sink
		int gap;
		int hold;
		gap = 0;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				m_tready <= 1'b0;
			end else if (sink_idle && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic [15:0] rng, input logic first);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= rng;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending, wait for every pending result, then let the core go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(input logic [31:0] a0, input logic [31:0] da,
			input logic [15:0] lo, input logic [15:0] hi, input logic [15:0] scl);
		cfg_we    <= 1'b1;
		cfg_addr  <= lp2c_pkg::CFG_ANGLE_START;
		cfg_wdata <= a0;
		@(posedge clk);
		cfg_addr  <= lp2c_pkg::CFG_ANGLE_STEP;
		cfg_wdata <= da;
		@(posedge clk);
		// upper bits of the 16-bit registers carry junk
		cfg_addr  <= lp2c_pkg::CFG_DIST_LO;
		cfg_wdata <= {16'($urandom), lo};
		@(posedge clk);
		cfg_addr  <= lp2c_pkg::CFG_DIST_HI;
		cfg_wdata <= {16'($urandom), hi};
		@(posedge clk);
		cfg_addr  <= lp2c_pkg::CFG_SCALE_TO_MAP;
		cfg_wdata <= {16'($urandom), scl};
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [15:0] pick_range(input logic [15:0] lo, input logic [15:0] hi);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0 || int'(hi) <= int'(lo) + 103)
			return 16'($urandom_range(0, 65535));
		if (sel == 1) begin
			case ($urandom_range(0, 3))
				0:       return lo;
				1:       return lo + 16'd1;
				2:       return hi - 16'd103;
				default: return hi - 16'd102;
			endcase
		end
		return 16'($urandom_range(int'(lo) + 1, int'(hi) - 103));
	endfunction

	initial begin : stim
		int          ph;
		int          n;
		logic [31:0] a0;
		logic [31:0] da;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] scl;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle  = 1'b1;
		sink_idle = 1'b1;

		// reset values: gate edges and the largest accepted range
		send_sample(16'd0, 1'b1);
		send_sample(16'd1, 1'b0);
		send_sample(16'd65432, 1'b0);
		send_sample(16'd65433, 1'b0);
		send_sample(16'd65535, 1'b1);
		send_sample(16'd12345, 1'b0);

		// extreme angles and full scale, angle wraps past the top
		settle();
		load_setting(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		send_sample(16'd65432, 1'b1);
		send_sample(16'd65432, 1'b0);
		send_sample(16'd40000, 1'b0);
		send_sample(16'd1, 1'b0);
		send_sample(16'd30000, 1'b0);

		// maximum below the margin: nothing gets through
		settle();
		load_setting(32'h4000_0000, 32'hC000_0000, 16'd0, 16'd101, 16'd10240);
		send_sample(16'd0, 1'b1);
		send_sample(16'd50, 1'b0);
		send_sample(16'd65535, 1'b0);

		// zero scale
		settle();
		load_setting(32'h7FFF_FFFF, 32'd1, 16'd100, 16'hFFFF, 16'd0);
		send_sample(16'd100, 1'b1);
		send_sample(16'd101, 1'b0);
		send_sample(16'd65000, 1'b0);

		// step across the quadrant boundary
		settle();
		load_setting(32'h3FFF_FFFF, 32'd1, 16'd0, 16'hFFFF, 16'd10240);
		send_sample(16'd30000, 1'b1);
		send_sample(16'd30000, 1'b0);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			a0 = $urandom;
			if ($urandom_range(0, 1) != 0)
				da = $urandom;
			else
				da = 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
			lo  = 16'($urandom_range(0, 3000));
			hi  = 16'($urandom_range(20000, 65535));
			scl = 16'($urandom);
			case (ph)
				0: begin
					lo  = 16'd0;
					hi  = 16'hFFFF;
					scl = 16'hFFFF;
				end
				2: begin
					a0 = 32'($urandom_range(0, 2)) - 32'd1;
					da = 32'h4000_0000;
				end
				3: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				4: scl = 16'($urandom_range(0, 255));
				5: begin
					a0 = 32'h8000_0000;
					da = 32'h7FFF_FFFF;
				end
				default: ;
			endcase
			if (ph == RAND_PHASES - 1) begin
				src_idle  = 1'b0;
				sink_idle = 1'b0;
			end
			settle();
			load_setting(a0, da, lo, hi, scl);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 40)
					hold_req = 1'b1;
				send_sample(pick_range(lo, hi), n == 0 || $urandom_range(0, 15) == 0);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		n = 0;
		while (pending != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
